[rtl/core/vec4_vector_alu_assert.svh]
// Assertion macros shared by the vector ALU RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef VEC4_VECTOR_ALU_ASSERT_SVH
`define VEC4_VECTOR_ALU_ASSERT_SVH
`ifndef SYNTHESIS
`define V4_ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("vec4_vector_alu assertion failed");
`define V4_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
		else $error("vec4_vector_alu assertion failed");
`else
`define V4_ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define V4_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`endif
`endif

[rtl/core/v4alu_pkg.sv]
// Shared types and constants for the vector ALU.
// No dependencies.
`default_nettype none
package v4alu_pkg;
	localparam int FRAC_BITS_DEF = 16;
	localparam int MAG_W = 33;
	localparam int RAD_W = 66;

	typedef enum logic [3:0] {
		OP_SCALE = 4'd0,
		OP_ADD   = 4'd1,
		OP_SUB   = 4'd2,
		OP_EQUAL = 4'd3,
		OP_DOT4  = 4'd4,
		OP_DOT3  = 4'd5,
		OP_CROSS = 4'd6,
		OP_MAG4  = 4'd7,
		OP_MAG3  = 4'd8,
		OP_NORM4 = 4'd9,
		OP_NORM3 = 4'd10
	} op_t;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] z;
		logic signed [31:0] w;
		logic signed [31:0] scalar;
		logic               eq;
		logic               sat;
		logic               dz;
	} res_t;

	typedef struct packed {
		res_t       res;
		logic       is_mag;
		logic       is_norm;
		logic       norm3;
		logic [3:0] neg;
	} tag_t;
endpackage
`default_nettype wire

[rtl/core/v4alu_front.sv]
// Front end: operand select, multipliers, sums and saturation (four stages).
// Depends on v4alu_pkg.
`default_nettype none
module v4alu_front #(
	parameter int FRAC_BITS = v4alu_pkg::FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic [3:0]                    op,
	input  logic signed [31:0]            a [4],
	input  logic signed [31:0]            b [4],
	input  logic signed [31:0]            s,
	output logic                          out_valid,
	output logic [v4alu_pkg::RAD_W-1:0]   rad,
	output logic [31:0]                   mag_a [4],
	output v4alu_pkg::tag_t               tag
);
	function automatic logic [32:0] sat32(input logic signed [65:0] v);
		if (v > 66'sd2147483647)
			return {1'b1, 32'h7fffffff};
		if (v < -66'sd2147483648)
			return {1'b1, 32'h80000000};
		return {1'b0, v[31:0]};
	endfunction

	// stage 1
	logic               valid_s1;
	v4alu_pkg::op_t     op_s1;
	logic signed [31:0] a_s1 [4];
	logic signed [31:0] b_s1 [4];
	logic signed [31:0] s_s1;
	// stage 2
	logic               valid_s2;
	v4alu_pkg::op_t     op_s2;
	logic signed [63:0] p_s2 [4];
	logic signed [63:0] q_s2 [3];
	logic signed [32:0] as_s2 [4];
	logic               eq_s2;
	logic [31:0]        abs_s2 [4];
	logic [3:0]         neg_s2;
	// stage 3
	logic               valid_s3;
	v4alu_pkg::op_t     op_s3;
	logic signed [63:0] scl_s3 [4];
	logic signed [64:0] crs_s3 [3];
	logic signed [65:0] dot_s3;
	logic [65:0]        rad_s3;
	logic signed [32:0] as_s3 [4];
	logic               eq_s3;
	logic [31:0]        abs_s3 [4];
	logic [3:0]         neg_s3;
	// stage 4
	logic               valid_s4;
	logic [65:0]        rad_s4;
	logic [31:0]        abs_s4 [4];
	v4alu_pkg::tag_t    tag_s4;

	logic signed [31:0] ma [4];
	logic signed [31:0] mb [4];
	logic signed [65:0] dot_c;
	logic [65:0]        rad_c;
	v4alu_pkg::tag_t    tag_c;
	logic [32:0]        t [4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			ma[i] = a_s1[i];
			mb[i] = b_s1[i];
		end
		case (op_s1)
			v4alu_pkg::OP_SCALE: begin
				for (int i = 0; i < 4; i++)
					mb[i] = s_s1;
			end
			v4alu_pkg::OP_CROSS: begin
				ma[0] = a_s1[1]; mb[0] = b_s1[2];
				ma[1] = a_s1[2]; mb[1] = b_s1[0];
				ma[2] = a_s1[0]; mb[2] = b_s1[1];
			end
			v4alu_pkg::OP_MAG4, v4alu_pkg::OP_MAG3,
			v4alu_pkg::OP_NORM4, v4alu_pkg::OP_NORM3: begin
				for (int i = 0; i < 4; i++)
					mb[i] = a_s1[i];
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		dot_c = 66'(p_s2[0]) + 66'(p_s2[1]) + 66'(p_s2[2]);
		if (op_s2 == v4alu_pkg::OP_DOT4)
			dot_c = dot_c + 66'(p_s2[3]);
		rad_c = 66'($unsigned(p_s2[0])) + 66'($unsigned(p_s2[1]))
			+ 66'($unsigned(p_s2[2]));
		if (op_s2 == v4alu_pkg::OP_MAG4 || op_s2 == v4alu_pkg::OP_NORM4)
			rad_c = rad_c + 66'($unsigned(p_s2[3]));
	end

	always_comb begin
		for (int i = 0; i < 4; i++)
			t[i] = '0;
		tag_c = '0;
		tag_c.neg = neg_s3;
		case (op_s3)
			v4alu_pkg::OP_SCALE: begin
				for (int i = 0; i < 4; i++)
					t[i] = sat32(66'(scl_s3[i]));
			end
			v4alu_pkg::OP_ADD, v4alu_pkg::OP_SUB: begin
				for (int i = 0; i < 4; i++)
					t[i] = sat32(66'(as_s3[i]));
			end
			v4alu_pkg::OP_EQUAL: tag_c.res.eq = eq_s3;
			v4alu_pkg::OP_DOT4, v4alu_pkg::OP_DOT3: begin
				t[0] = sat32(dot_s3 >>> FRAC_BITS);
				tag_c.res.scalar = t[0][31:0];
				tag_c.res.sat = t[0][32];
				t[0] = '0;
			end
			v4alu_pkg::OP_CROSS: begin
				for (int i = 0; i < 3; i++)
					t[i] = sat32(66'(crs_s3[i] >>> FRAC_BITS));
			end
			v4alu_pkg::OP_MAG4, v4alu_pkg::OP_MAG3: tag_c.is_mag = 1'b1;
			v4alu_pkg::OP_NORM4: tag_c.is_norm = 1'b1;
			v4alu_pkg::OP_NORM3: begin
				tag_c.is_norm = 1'b1;
				tag_c.norm3 = 1'b1;
			end
			default: begin
			end
		endcase
		tag_c.res.x = t[0][31:0];
		tag_c.res.y = t[1][31:0];
		tag_c.res.z = t[2][31:0];
		tag_c.res.w = t[3][31:0];
		tag_c.res.sat = tag_c.res.sat | t[0][32] | t[1][32] | t[2][32] | t[3][32];
	end

	always_ff @(posedge clk) begin
		op_s1 <= v4alu_pkg::op_t'(op);
		s_s1 <= s;
		for (int i = 0; i < 4; i++) begin
			a_s1[i] <= a[i];
			b_s1[i] <= b[i];
		end

		op_s2 <= op_s1;
		for (int i = 0; i < 4; i++) begin
			p_s2[i] <= ma[i] * mb[i];
			as_s2[i] <= (op_s1 == v4alu_pkg::OP_SUB) ? 33'(a_s1[i]) - 33'(b_s1[i])
				: 33'(a_s1[i]) + 33'(b_s1[i]);
			abs_s2[i] <= a_s1[i][31] ? 32'(-a_s1[i]) : 32'(a_s1[i]);
			neg_s2[i] <= a_s1[i][31];
		end
		q_s2[0] <= a_s1[2] * b_s1[1];
		q_s2[1] <= a_s1[0] * b_s1[2];
		q_s2[2] <= a_s1[1] * b_s1[0];
		eq_s2 <= (a_s1[0] == b_s1[0]) && (a_s1[1] == b_s1[1])
			&& (a_s1[2] == b_s1[2]) && (a_s1[3] == b_s1[3]);

		op_s3 <= op_s2;
		dot_s3 <= dot_c;
		rad_s3 <= rad_c;
		eq_s3 <= eq_s2;
		neg_s3 <= neg_s2;
		for (int i = 0; i < 4; i++) begin
			scl_s3[i] <= p_s2[i] >>> FRAC_BITS;
			as_s3[i] <= as_s2[i];
			abs_s3[i] <= abs_s2[i];
		end
		for (int i = 0; i < 3; i++)
			crs_s3[i] <= 65'(p_s2[i]) - 65'(q_s2[i]);

		rad_s4 <= rad_s3;
		tag_s4 <= tag_c;
		for (int i = 0; i < 4; i++)
			abs_s4[i] <= abs_s3[i];
	end

	assign out_valid = valid_s4;
	assign rad = rad_s4;
	assign mag_a = abs_s4;
	assign tag = tag_s4;
endmodule
`default_nettype wire

[rtl/core/v4alu_sqrt.sv]
// Pipelined integer square root, one root bit per stage.
// Depends on v4alu_pkg.
`default_nettype none
module v4alu_sqrt #(
	parameter int TAG_W = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic [v4alu_pkg::RAD_W-1:0] rad,
	input  logic [TAG_W-1:0]            in_tag,
	output logic                        out_valid,
	output logic [v4alu_pkg::MAG_W-1:0] root,
	output logic [TAG_W-1:0]            out_tag
);
	localparam int N  = v4alu_pkg::MAG_W;
	localparam int RW = v4alu_pkg::MAG_W + 3;
	localparam int DW = v4alu_pkg::RAD_W;

	logic          vld_s [0:N];
	logic [RW-1:0] rem_s [0:N];
	logic [N-1:0]  root_s [0:N];
	logic [DW-1:0] rad_s [0:N];
	logic [TAG_W-1:0] tag_s [0:N];

	assign vld_s[0] = in_valid;
	assign rem_s[0] = '0;
	assign root_s[0] = '0;
	assign rad_s[0] = rad;
	assign tag_s[0] = in_tag;

	for (genvar k = 0; k < N; k++) begin : g_stage
		logic [RW-1:0] cur;
		logic [RW-1:0] trial;
		logic          take;

		always_comb begin
			cur = {rem_s[k][RW-3:0], rad_s[k][DW-1:DW-2]};
			trial = RW'({root_s[k], 2'b01});
			take = cur >= trial;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else begin
				vld_s[k+1] <= vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k+1] <= take ? cur - trial : cur;
			root_s[k+1] <= {root_s[k][N-2:0], take};
			rad_s[k+1] <= {rad_s[k][DW-3:0], 2'b00};
			tag_s[k+1] <= tag_s[k];
		end
	end

	assign out_valid = vld_s[N];
	assign root = root_s[N];
	assign out_tag = tag_s[N];
endmodule
`default_nettype wire

[rtl/core/v4alu_div.sv]
// Pipelined restoring divider, four lanes sharing one divisor, one quotient bit per stage.
// Depends on v4alu_pkg.
`default_nettype none
module v4alu_div #(
	parameter int FRAC_BITS = v4alu_pkg::FRAC_BITS_DEF,
	parameter int TAG_W = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic [v4alu_pkg::MAG_W-1:0] divisor,
	input  logic [31:0]                 dvd [4],
	input  logic [TAG_W-1:0]            in_tag,
	output logic                        out_valid,
	output logic [v4alu_pkg::MAG_W-1:0] out_divisor,
	output logic [FRAC_BITS:0]          quot [4],
	output logic [TAG_W-1:0]            out_tag
);
	localparam int NS = FRAC_BITS + 1;
	localparam int RW = v4alu_pkg::MAG_W + FRAC_BITS;
	localparam int QW = FRAC_BITS + 1;

	logic                        vld_s [0:NS];
	logic [v4alu_pkg::MAG_W-1:0] dv_s [0:NS];
	logic [RW-1:0]               r_s [0:NS][4];
	logic [QW-1:0]               q_s [0:NS][4];
	logic [TAG_W-1:0]            tag_s [0:NS];

	assign vld_s[0] = in_valid;
	assign dv_s[0] = divisor;
	assign tag_s[0] = in_tag;
	for (genvar l = 0; l < 4; l++) begin : g_init
		assign r_s[0][l] = RW'(dvd[l]) << FRAC_BITS;
		assign q_s[0][l] = '0;
	end

	for (genvar j = 0; j < NS; j++) begin : g_stage
		logic [RW-1:0] dsh;
		assign dsh = RW'(dv_s[j]) << (FRAC_BITS - j);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j+1] <= 1'b0;
			end else begin
				vld_s[j+1] <= vld_s[j];
			end
		end

		always_ff @(posedge clk) begin
			dv_s[j+1] <= dv_s[j];
			tag_s[j+1] <= tag_s[j];
			for (int l = 0; l < 4; l++) begin
				if (r_s[j][l] >= dsh) begin
					r_s[j+1][l] <= r_s[j][l] - dsh;
					q_s[j+1][l] <= {q_s[j][l][QW-2:0], 1'b1};
				end else begin
					r_s[j+1][l] <= r_s[j][l];
					q_s[j+1][l] <= {q_s[j][l][QW-2:0], 1'b0};
				end
			end
		end
	end

	assign out_valid = vld_s[NS];
	assign out_divisor = dv_s[NS];
	assign out_tag = tag_s[NS];
	assign quot = q_s[NS];
endmodule
`default_nettype wire

[rtl/core/vec4_vector_alu.sv]
// Top level of the four-component Q16.16 vector ALU.
// Depends on v4alu_pkg, v4alu_front, v4alu_sqrt, v4alu_div and vec4_vector_alu_assert.svh.
//
//   channel   handshake      payload
//   input     start / busy   op, a_x..a_w, b_x..b_w, scale_factor
//   result    done strobe    out_x..out_w, scalar_out, is_equal, saturated, divide_by_zero
//
// One beat is accepted every cycle; busy stays low.
// The pipeline holds four front stages (multipliers and sums),
// 33 square-root stages, FRAC_BITS + 1 divider stages and the output register.
// Reset clears only the valid bits; the receiver cannot stall the result.
`default_nettype none
`include "vec4_vector_alu_assert.svh"
module vec4_vector_alu #(
	parameter int FRAC_BITS = v4alu_pkg::FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [3:0]         op,
	input  logic signed [31:0] a_x,
	input  logic signed [31:0] a_y,
	input  logic signed [31:0] a_z,
	input  logic signed [31:0] a_w,
	input  logic signed [31:0] b_x,
	input  logic signed [31:0] b_y,
	input  logic signed [31:0] b_z,
	input  logic signed [31:0] b_w,
	input  logic signed [31:0] scale_factor,
	output logic               done,
	output logic signed [31:0] out_x,
	output logic signed [31:0] out_y,
	output logic signed [31:0] out_z,
	output logic signed [31:0] out_w,
	output logic signed [31:0] scalar_out,
	output logic               is_equal,
	output logic               saturated,
	output logic               divide_by_zero
);
	localparam int TAG_W = $bits(v4alu_pkg::tag_t);
	localparam int LAT = FRAC_BITS + 39;

	logic signed [31:0] a_v [4];
	logic signed [31:0] b_v [4];
	logic               fe_valid;
	logic [v4alu_pkg::RAD_W-1:0] fe_rad;
	logic [31:0]        fe_abs [4];
	v4alu_pkg::tag_t    fe_tag;

	logic               sq_valid;
	logic [v4alu_pkg::MAG_W-1:0] sq_root;
	logic [TAG_W-1:0]   sq_tag;

	logic               dv_valid;
	logic [v4alu_pkg::MAG_W-1:0] dv_root;
	logic [FRAC_BITS:0] dv_quot [4];
	logic [TAG_W-1:0]   dv_tag;

	v4alu_pkg::tag_t    fin_tag;
	v4alu_pkg::res_t    fin;
	logic [31:0]        nv [4];

	logic               done_q;
	v4alu_pkg::res_t    res_q;

	assign a_v[0] = a_x;
	assign a_v[1] = a_y;
	assign a_v[2] = a_z;
	assign a_v[3] = a_w;
	assign b_v[0] = b_x;
	assign b_v[1] = b_y;
	assign b_v[2] = b_z;
	assign b_v[3] = b_w;

	v4alu_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(start && !busy), .op(op),
		.a(a_v), .b(b_v), .s(scale_factor),
		.out_valid(fe_valid), .rad(fe_rad), .mag_a(fe_abs), .tag(fe_tag)
	);

	// magnitudes ride along with the tag so the divider sees them in step
	logic [TAG_W+128-1:0] sq_in_tag;
	logic [TAG_W+128-1:0] sq_out_tag;
	logic [31:0]          sq_abs [4];
	assign sq_in_tag = {fe_tag, fe_abs[0], fe_abs[1], fe_abs[2], fe_abs[3]};
	assign sq_tag = sq_out_tag[TAG_W+127:128];
	assign sq_abs[0] = sq_out_tag[127:96];
	assign sq_abs[1] = sq_out_tag[95:64];
	assign sq_abs[2] = sq_out_tag[63:32];
	assign sq_abs[3] = sq_out_tag[31:0];

	v4alu_sqrt #(.TAG_W(TAG_W + 128)) u_sqrt (
		.clk(clk), .arst_n(arst_n), .in_valid(fe_valid), .rad(fe_rad),
		.in_tag(sq_in_tag), .out_valid(sq_valid), .root(sq_root), .out_tag(sq_out_tag)
	);

	v4alu_div #(.FRAC_BITS(FRAC_BITS), .TAG_W(TAG_W)) u_div (
		.clk(clk), .arst_n(arst_n), .in_valid(sq_valid), .divisor(sq_root),
		.dvd(sq_abs), .in_tag(sq_tag), .out_valid(dv_valid),
		.out_divisor(dv_root), .quot(dv_quot), .out_tag(dv_tag)
	);

	always_comb begin
		fin_tag = v4alu_pkg::tag_t'(dv_tag);
		fin = fin_tag.res;
		for (int i = 0; i < 4; i++) begin
			nv[i] = 32'(dv_quot[i]);
			if (fin_tag.neg[i])
				nv[i] = -nv[i];
		end
		if (fin_tag.is_mag) begin
			if (dv_root[32:31] != 2'b00) begin
				fin.scalar = 32'h7fffffff;
				fin.sat = 1'b1;
			end else begin
				fin.scalar = dv_root[31:0];
			end
		end
		if (fin_tag.is_norm) begin
			if (dv_root == '0) begin
				fin.dz = 1'b1;
			end else begin
				fin.x = nv[0];
				fin.y = nv[1];
				fin.z = nv[2];
				fin.w = fin_tag.norm3 ? 32'sd0 : nv[3];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= dv_valid;
		end
	end

	always_ff @(posedge clk) begin
		res_q <= fin;
	end

	assign busy = 1'b0;
	assign done = done_q;
	assign out_x = res_q.x;
	assign out_y = res_q.y;
	assign out_z = res_q.z;
	assign out_w = res_q.w;
	assign scalar_out = res_q.scalar;
	assign is_equal = res_q.eq;
	assign saturated = res_q.sat;
	assign divide_by_zero = res_q.dz;

	`V4_ASSERT_IMPL(a_latency, clk, arst_n, start && !busy, ##LAT done)
	`V4_ASSERT_IMPL(a_no_orphan, clk, arst_n, done, $past(start, LAT))
	`V4_ASSERT_IMPL(a_dz_zero, clk, arst_n, done && divide_by_zero,
		out_x == 0 && out_y == 0 && out_z == 0 && out_w == 0 && scalar_out == 0)
endmodule
`default_nettype wire
